>>> hdl/pcsm_pkg.sv
// shared opcodes, function codes, status codes and divider interface types
`timescale 1ns / 1ps

package pcsm_pkg;

  // opcodes
  localparam logic [2:0] OP_LIT = 3'd0;
  localparam logic [2:0] OP_OPR = 3'd1;
  localparam logic [2:0] OP_LOD = 3'd2;
  localparam logic [2:0] OP_STO = 3'd3;
  localparam logic [2:0] OP_CAL = 3'd4;
  localparam logic [2:0] OP_INT = 3'd5;
  localparam logic [2:0] OP_JMP = 3'd6;
  localparam logic [2:0] OP_JPC = 3'd7;

  // opr function numbers
  localparam logic [10:0] FN_RET = 11'd0;
  localparam logic [10:0] FN_NEG = 11'd1;
  localparam logic [10:0] FN_ADD = 11'd2;
  localparam logic [10:0] FN_SUB = 11'd3;
  localparam logic [10:0] FN_MUL = 11'd4;
  localparam logic [10:0] FN_DIV = 11'd5;
  localparam logic [10:0] FN_ODD = 11'd6;
  localparam logic [10:0] FN_EQ  = 11'd7;
  localparam logic [10:0] FN_NE  = 11'd8;
  localparam logic [10:0] FN_LT  = 11'd9;
  localparam logic [10:0] FN_LE  = 11'd10;
  localparam logic [10:0] FN_GT  = 11'd11;
  localparam logic [10:0] FN_GE  = 11'd12;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

>>> hdl/pcsm_div.sv
// bit-serial unsigned 32-bit divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pcsm_div import pcsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;
  logic [32:0] rem_sh;
  logic        fit;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem_q, quo_q[31]};
  assign fit    = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      cnt_q <= '0;
      if (req_i.dividend < req_i.divisor) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
      if (req_i.dividend < req_i.divisor) begin
        quo_q <= '0;
        rem_q <= req_i.dividend;
      end else begin
        quo_q <= req_i.dividend;
        rem_q <= '0;
      end
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], fit};
      rem_q <= fit ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/pcsm_ram.sv
// stack word memory, one write and one registered read port
`timescale 1ns / 1ps

module pcsm_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pcode_stack_machine_step_top.sv
// Each beat is decoded, run through its op's states and closed by a read of the stack top;
// a DIV with a nonzero divisor waits on the divider (one quotient bit a cycle), and LOD, STO
// and CAL read one link word for each static link followed.
// Throughput: one instruction at a time; the next beat can be taken in the cycle after the result
// is loaded, and a stalled result beat holds the machine.
// Reset: pointers reset at once, then a clearing pass zeroes every stack word, tready held low.
`timescale 1ns / 1ps

module pcode_stack_machine_step_top import pcsm_pkg::*; #(
  parameter int STACK_DEPTH = 512,
  parameter int MAX_LEVEL   = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // op [2:0], level [4:3], operand [15:5]
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // next_pc [10:0], top_value [42:11], top_index [51:43], halted [52], status [54:53]
  output logic [55:0] m_axis_tdata_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(STACK_DEPTH);
  localparam logic [AW-1:0] TOP_ADDR = AW'(STACK_DEPTH - 1);

  // state codes
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DEC    = 5'd2;
  localparam logic [4:0] S_RET1   = 5'd3;
  localparam logic [4:0] S_RET2   = 5'd4;
  localparam logic [4:0] S_RET3   = 5'd5;
  localparam logic [4:0] S_UN     = 5'd6;
  localparam logic [4:0] S_BIN1   = 5'd7;
  localparam logic [4:0] S_BIN2   = 5'd8;
  localparam logic [4:0] S_ALU    = 5'd9;
  localparam logic [4:0] S_DIVW   = 5'd10;
  localparam logic [4:0] S_WRR    = 5'd11;
  localparam logic [4:0] S_WRD    = 5'd12;
  localparam logic [4:0] S_WWT    = 5'd13;
  localparam logic [4:0] S_LINKED = 5'd15;
  localparam logic [4:0] S_LOD1   = 5'd17;
  localparam logic [4:0] S_STO1   = 5'd18;
  localparam logic [4:0] S_CAL2   = 5'd19;
  localparam logic [4:0] S_CAL3   = 5'd20;
  localparam logic [4:0] S_JPC1   = 5'd22;
  localparam logic [4:0] S_TOP    = 5'd23;
  localparam logic [4:0] S_TOPW   = 5'd24;

  // small wrap: returns {overflow, address} of t + k
  function automatic logic [AW:0] wrap_s(input logic [AW-1:0] t, input logic [1:0] k);
    logic [AW:0] s;
    s = {1'b0, t} + (AW+1)'(k);
    if ({{(31-AW){1'b0}}, s} >= DEPTH_W) begin
      wrap_s = {1'b1, AW'(s - (AW+1)'(STACK_DEPTH))};
    end else begin
      wrap_s = {1'b0, s[AW-1:0]};
    end
  endfunction

  function automatic logic [AW-1:0] pop_idx(input logic [AW-1:0] t);
    pop_idx = (t == '0) ? TOP_ADDR : t - AW'(1);
  endfunction

  logic [4:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0]    op_q, op_d;
  logic [1:0]    lv_q, lv_d;
  logic [10:0]   a_q, a_d;
  logic [AW-1:0] t_q, t_d;
  logic [AW-1:0] b_q, b_d;
  logic [10:0]   pc_q, pc_d;
  logic [10:0]   p_q, p_d;
  logic [31:0]   x_q, x_d;
  logic [31:0]   y_q, y_d;
  logic [31:0]   r_q, r_d;
  logic [AW-1:0] bl_q, bl_d;
  logic [AW-1:0] wa_q, wa_d;
  logic [1:0]    lc_q, lc_d;
  logic          ovf_q, ovf_d;
  logic          div0_q, div0_d;

  logic          mv_q;
  logic [55:0]   mdata_q;
  logic          out_load;
  logic [55:0]   out_data;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  div_req_t      dreq;
  div_rsp_t      drsp;

  logic          s_acc;
  logic [AW:0]   w1, w2, w3;
  logic [31:0]   sum_ta, sum_ba;
  logic          nx, ny;
  logic [1:0]    lc_init;
  logic [10:0]   fin_pc;
  logic [1:0]    fin_st;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign w1     = wrap_s(t_q, 2'd1);
  assign w2     = wrap_s(t_q, 2'd2);
  assign w3     = wrap_s(t_q, 2'd3);
  assign sum_ta = 32'(t_q) + 32'(a_q);
  assign sum_ba = 32'(bl_q) + 32'(a_q);
  assign nx     = x_q[31];
  assign ny     = y_q[31];
  assign lc_init = (32'(lv_q) > 32'(MAX_LEVEL)) ? 2'(MAX_LEVEL) : lv_q;

  assign fin_pc = p_q;
  assign fin_st = ovf_q ? ST_OVF : (div0_q ? ST_DIV0 : ST_OK);
  assign out_data = {1'b0, fin_st, (fin_pc == 11'd0), 9'(t_q), rdata, fin_pc};

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    op_d    = op_q;
    lv_d    = lv_q;
    a_d     = a_q;
    t_d     = t_q;
    b_d     = b_q;
    pc_d    = pc_q;
    p_d     = p_q;
    x_d     = x_q;
    y_d     = y_q;
    r_d     = r_q;
    bl_d    = bl_q;
    wa_d    = wa_q;
    lc_d    = lc_q;
    ovf_d   = ovf_q;
    div0_d  = div0_q;
    we      = 1'b0;
    waddr   = t_q;
    wdata   = '0;
    re      = 1'b0;
    raddr   = t_q;
    dreq    = '0;
    out_load = 1'b0;

    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == TOP_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          op_d    = s_axis_tdata_i[2:0];
          lv_d    = s_axis_tdata_i[4:3];
          a_d     = s_axis_tdata_i[15:5];
          p_d     = pc_q + 11'd1;
          ovf_d   = 1'b0;
          div0_d  = 1'b0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (op_q)
          OP_LIT: begin
            we      = 1'b1;
            waddr   = w1[AW-1:0];
            wdata   = 32'(a_q);
            t_d     = w1[AW-1:0];
            ovf_d   = ovf_q | w1[AW];
            state_d = S_TOP;
          end
          OP_OPR: begin
            if (a_q == FN_RET) begin
              t_d     = pop_idx(b_q);
              state_d = S_RET1;
            end else if (a_q == FN_NEG || a_q == FN_ODD) begin
              re      = 1'b1;
              state_d = S_UN;
            end else if (a_q <= FN_GE) begin
              t_d     = pop_idx(t_q);
              re      = 1'b1;
              raddr   = pop_idx(t_q);
              state_d = S_BIN1;
            end else begin
              state_d = S_TOP;
            end
          end
          OP_LOD, OP_STO, OP_CAL: begin
            bl_d    = b_q;
            lc_d    = lc_init;
            state_d = (lc_init != 2'd0) ? S_WRD : S_LINKED;
          end
          OP_INT: begin
            // STACK_DEPTH must be a power of two, unchecked by the block, so the wrap is the low bits
            t_d     = sum_ta[AW-1:0];
            ovf_d   = ovf_q | (sum_ta >= DEPTH_W);
            state_d = S_TOP;
          end
          OP_JMP: begin
            p_d     = a_q;
            state_d = S_TOP;
          end
          OP_JPC: begin
            re      = 1'b1;
            state_d = S_JPC1;
          end
          default: state_d = S_TOP;
        endcase
      end
      // return: fetch saved pc, then saved base
      S_RET1: begin
        re      = 1'b1;
        raddr   = w3[AW-1:0];
        ovf_d   = ovf_q | w3[AW];
        state_d = S_RET2;
      end
      S_RET2: begin
        p_d     = rdata[10:0];
        re      = 1'b1;
        raddr   = w2[AW-1:0];
        ovf_d   = ovf_q | w2[AW];
        state_d = S_RET3;
      end
      S_RET3: begin
        b_d     = rdata[AW-1:0];
        state_d = S_TOP;
      end
      S_UN: begin
        we      = 1'b1;
        wdata   = (a_q == FN_NEG) ? 32'd0 - rdata : {31'd0, rdata[0]};
        state_d = S_TOP;
      end
      // binary operands
      S_BIN1: begin
        x_d     = rdata;
        re      = 1'b1;
        raddr   = w1[AW-1:0];
        ovf_d   = ovf_q | w1[AW];
        state_d = S_BIN2;
      end
      S_BIN2: begin
        y_d     = rdata;
        state_d = S_ALU;
      end
      S_ALU: begin
        we      = 1'b1;
        state_d = S_TOP;
        case (a_q)
          FN_ADD: wdata = x_q + y_q;
          FN_SUB: wdata = x_q - y_q;
          FN_EQ:  wdata = 32'(x_q == y_q);
          FN_NE:  wdata = 32'(x_q != y_q);
          FN_LT:  wdata = 32'($signed(x_q) < $signed(y_q));
          FN_LE:  wdata = 32'(!($signed(y_q) < $signed(x_q)));
          FN_GT:  wdata = 32'($signed(y_q) < $signed(x_q));
          FN_GE:  wdata = 32'(!($signed(x_q) < $signed(y_q)));
          FN_MUL: begin
            we      = 1'b0;
            r_d     = 32'(x_q * y_q);
            state_d = S_WRR;
          end
          FN_DIV: begin
            if (y_q == 32'd0) begin
              wdata  = 32'd0;
              div0_d = 1'b1;
            end else begin
              we            = 1'b0;
              dreq.start    = 1'b1;
              dreq.dividend = nx ? 32'd0 - x_q : x_q;
              dreq.divisor  = ny ? 32'd0 - y_q : y_q;
              state_d       = S_DIVW;
            end
          end
          default: wdata = '0;
        endcase
      end
      S_DIVW: begin
        if (drsp.done) begin
          r_d     = (nx ^ ny) ? 32'd0 - drsp.quo : drsp.quo;
          state_d = S_WRR;
        end
      end
      S_WRR: begin
        we      = 1'b1;
        wdata   = r_q;
        state_d = S_TOP;
      end
      // static link walk, link word taken modulo the stack depth
      S_WRD: begin
        re      = 1'b1;
        raddr   = bl_q;
        state_d = S_WWT;
      end
      S_WWT: begin
        bl_d    = rdata[AW-1:0];
        lc_d    = lc_q - 2'd1;
        state_d = (lc_q == 2'd1) ? S_LINKED : S_WRD;
      end
      S_LINKED: begin
        if (op_q == OP_CAL) begin
          we      = 1'b1;
          waddr   = w1[AW-1:0];
          wdata   = 32'(bl_q);
          ovf_d   = ovf_q | w1[AW];
          state_d = S_CAL2;
        end else begin
          wa_d  = sum_ba[AW-1:0];
          ovf_d = ovf_q | (sum_ba >= DEPTH_W);
          re    = 1'b1;
          if (op_q == OP_LOD) begin
            raddr   = sum_ba[AW-1:0];
            state_d = S_LOD1;
          end else begin
            state_d = S_STO1;
          end
        end
      end
      S_LOD1: begin
        we      = 1'b1;
        waddr   = w1[AW-1:0];
        wdata   = rdata;
        t_d     = w1[AW-1:0];
        ovf_d   = ovf_q | w1[AW];
        state_d = S_TOP;
      end
      S_STO1: begin
        we      = 1'b1;
        waddr   = wa_q;
        wdata   = rdata;
        t_d     = pop_idx(t_q);
        state_d = S_TOP;
      end
      S_CAL2: begin
        we      = 1'b1;
        waddr   = w2[AW-1:0];
        wdata   = 32'(b_q);
        ovf_d   = ovf_q | w2[AW];
        state_d = S_CAL3;
      end
      S_CAL3: begin
        we      = 1'b1;
        waddr   = w3[AW-1:0];
        wdata   = 32'(p_q);
        ovf_d   = ovf_q | w3[AW];
        b_d     = w1[AW-1:0];
        p_d     = a_q;
        state_d = S_TOP;
      end
      S_JPC1: begin
        if (rdata == 32'd0) begin
          p_d = a_q;
        end
        t_d     = pop_idx(t_q);
        state_d = S_TOP;
      end
      S_TOP: begin
        re      = 1'b1;
        state_d = S_TOPW;
      end
      S_TOPW: begin
        if (!mv_q || m_axis_tready_i) begin
          out_load = 1'b1;
          pc_d     = p_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      t_q     <= '0;
      b_q     <= AW'(1);
      pc_q    <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      t_q     <= t_d;
      b_q     <= b_d;
      pc_q    <= pc_d;
      if (out_load) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        mv_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    lv_q   <= lv_d;
    a_q    <= a_d;
    p_q    <= p_d;
    x_q    <= x_d;
    y_q    <= y_d;
    r_q    <= r_d;
    bl_q   <= bl_d;
    wa_q   <= wa_d;
    lc_q   <= lc_d;
    ovf_q  <= ovf_d;
    div0_q <= div0_d;
    if (out_load) begin
      mdata_q <= out_data;
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;

  pcsm_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pcsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

endmodule

>>> hdl/pcsm_chk.sv
// port-level checks for the stack machine top, bound to the top level
`timescale 1ns / 1ps

module pcsm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // one instruction at a time
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

  // halted mirrors a zero next pc
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[52] == (m_axis_tdata_o[10:0] == 11'd0)))
    else $error("halted does not match next pc");

  // status code and pad bit in range
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[54:53] != 2'd3) && !m_axis_tdata_o[55])
    else $error("bad status or pad bit");

endmodule

bind pcode_stack_machine_step_top pcsm_chk u_pcsm_chk (.*);
